[rtl/bda_pkg.sv]
// Shared types and constants for the button debouncer with auto-repeat.
// No dependencies.
`default_nettype none

package bda_pkg;

   // Field widths
   localparam int BTN_WIDTH      = 3;
   localparam int DEBOUNCE_WIDTH = 8;
   localparam int HOLD_WIDTH     = 16;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 16;

   // Register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DEBOUNCE_TIME = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_REPEAT_AFTER  = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_REPEAT_RATE   = 2'd2;

   // Reset values of the registers
   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_TIME_RESET = 8'd4;
   localparam logic [HOLD_WIDTH-1:0]     REPEAT_AFTER_RESET  = 16'd512;
   localparam logic [HOLD_WIDTH-1:0]     REPEAT_RATE_RESET   = 16'd64;

   // Item commands
   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_CONSUME = 1'b1;

   typedef struct packed {
      logic [DEBOUNCE_WIDTH-1:0] debounce_time;
      logic [HOLD_WIDTH-1:0]     repeat_after;
      logic [HOLD_WIDTH-1:0]     repeat_rate;
   } cfg_type;

   typedef struct packed {
      logic [BTN_WIDTH-1:0] press_event;
      logic                 click;
      logic [BTN_WIDTH-1:0] debounced_buttons;
      logic                 repeat_active;
   } result_type;

endpackage

`default_nettype wire

[rtl/bda_csr.sv]
// Configuration registers of the debouncer.
// Depends on bda_pkg.
`default_nettype none

module bda_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [bda_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  wire logic [bda_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   output bda_pkg::cfg_type                          cfg
);
   import bda_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time <= DEBOUNCE_TIME_RESET;
         cfg_ff.repeat_after  <= REPEAT_AFTER_RESET;
         cfg_ff.repeat_rate   <= REPEAT_RATE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DEBOUNCE_TIME: begin
               cfg_ff.debounce_time <= csr_write_data[DEBOUNCE_WIDTH-1:0];
            end
            CSR_REPEAT_AFTER: begin
               cfg_ff.repeat_after <= csr_write_data[HOLD_WIDTH-1:0];
            end
            CSR_REPEAT_RATE: begin
               cfg_ff.repeat_rate <= csr_write_data[HOLD_WIDTH-1:0];
            end
            default: begin
               // unmapped index: write ignored
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[rtl/bda_core.sv]
// Debounce and hold/repeat state with its single-pass update per item.
// Depends on bda_pkg.
`default_nettype none

module bda_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  bda_pkg::cfg_type                    cfg,
   input  wire logic                           item_accept,
   input  wire logic                           command,
   input  wire logic [bda_pkg::BTN_WIDTH-1:0]  sensed_buttons,
   output bda_pkg::result_type                 result
);
   import bda_pkg::*;

   logic [BTN_WIDTH-1:0]      candidate_ff, candidate_in;
   logic [BTN_WIDTH-1:0]      committed_ff, committed_in;
   logic                      consumed_ff, consumed_in;
   logic                      repeat_ff, repeat_in;
   logic [DEBOUNCE_WIDTH-1:0] stable_ff, stable_in;
   logic [HOLD_WIDTH-1:0]     hold_ff, hold_in;

   logic                      is_tick;
   logic                      match;
   logic [DEBOUNCE_WIDTH-1:0] stable_inc;
   logic                      commit;
   logic [BTN_WIDTH-1:0]      committed_new;
   logic                      repeat_base;
   logic                      consumed_base;
   logic [HOLD_WIDTH-1:0]     hold_inc;
   logic                      can_consume;

   assign is_tick    = item_accept && (command == CMD_TICK);
   // sample differs from the committed set and repeats the candidate
   assign match      = (committed_ff != sensed_buttons) && (candidate_ff == sensed_buttons);
   assign stable_inc = (stable_ff == '1) ? stable_ff : stable_ff + 1'b1;
   assign commit     = is_tick && match && (stable_inc >= cfg.debounce_time);

   assign committed_new = commit ? sensed_buttons : committed_ff;
   assign repeat_base   = commit ? 1'b0 : repeat_ff;
   assign consumed_base = commit ? 1'b0 : consumed_ff;
   // commit restarts hold count from zero before this tick's advance
   assign hold_inc      = commit ? HOLD_WIDTH'(1)
                                 : ((hold_ff == '1) ? hold_ff : hold_ff + 1'b1);
   assign can_consume   = !consumed_ff && (committed_ff != '0);

   always_comb begin
      candidate_in = candidate_ff;
      committed_in = committed_ff;
      consumed_in  = consumed_ff;
      repeat_in    = repeat_ff;
      stable_in    = stable_ff;
      hold_in      = hold_ff;
      result.press_event = '0;
      result.click       = 1'b0;

      if (is_tick) begin
         if (match) begin
            stable_in = stable_inc;
         end else begin
            candidate_in = sensed_buttons;
            stable_in    = '0;
         end
         committed_in = committed_new;
         consumed_in  = consumed_base;
         repeat_in    = repeat_base;
         hold_in      = commit ? '0 : hold_ff;
         if (committed_new != '0) begin
            hold_in = hold_inc;
            if (repeat_base) begin
               if (hold_inc >= cfg.repeat_rate) begin
                  consumed_in = 1'b0;
                  hold_in     = '0;
               end
            end else if (hold_inc >= cfg.repeat_after) begin
               repeat_in = 1'b1;
            end
         end
      end else if (item_accept && can_consume) begin
         consumed_in        = 1'b1;
         result.press_event = committed_ff;
         result.click       = 1'b1;
      end

      result.debounced_buttons = committed_in;
      result.repeat_active     = repeat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         candidate_ff <= '0;
         committed_ff <= '0;
         consumed_ff  <= 1'b0;
         repeat_ff    <= 1'b0;
         stable_ff    <= '0;
         hold_ff      <= '0;
      end else begin
         candidate_ff <= candidate_in;
         committed_ff <= committed_in;
         consumed_ff  <= consumed_in;
         repeat_ff    <= repeat_in;
         stable_ff    <= stable_in;
         hold_ff      <= hold_in;
      end
   end

endmodule

`default_nettype wire

[rtl/bda_out.sv]
// Result register: holds one result item until the receiver takes it.
// Depends on bda_pkg.
`default_nettype none

module bda_out (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           load,
   input  bda_pkg::result_type result,
   output logic                ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output bda_pkg::result_type rsp_data
);
   import bda_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // free when empty or being emptied this cycle
   assign ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

[rtl/button_debounce_autorepeat.sv]
// Top level of the three-button debouncer with press-and-hold auto-repeat.
// Depends on bda_pkg, bda_csr, bda_core and bda_out.
//
// Usage:
//  - req_ channel: one item per handshake. req_command low is a tick that
//    carries req_sensed_buttons; high is a consume request (buttons ignored).
//  - rsp_ channel: exactly one result item per accepted item, in order:
//    press_event/click (consume requests only), the committed set and the
//    repeat flag as they stand after the item.
//  - csr_ port: write debounce_time (0), repeat_after (1), repeat_rate (2)
//    only while the block is idle; other indexes are ignored.
//  - The result is registered: it appears in the cycle after acceptance.
//  - Throughput: one item per cycle while no result is stalled. The state
//    update is a single pass of counter increments and compares, and the
//    only register between input and output is the result register.
//  - Stall: while rsp_ready is low the result is held and req_ready drops
//    (one result in flight); req_ready is high whenever the result register
//    is empty or is being emptied in the same cycle.
//  - Reset (synchronous): all debounce state cleared, registers back to
//    4 / 512 / 64, no result pending.
`default_nettype none

module button_debounce_autorepeat (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // item input
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_command,
   input  wire logic [bda_pkg::BTN_WIDTH-1:0]       req_sensed_buttons,
   // result output
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [bda_pkg::BTN_WIDTH-1:0]            rsp_press_event,
   output logic                                     rsp_click,
   output logic [bda_pkg::BTN_WIDTH-1:0]            rsp_debounced_buttons,
   output logic                                     rsp_repeat_active,
   // configuration
   input  wire logic                                csr_write_enable,
   input  wire logic [bda_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  wire logic [bda_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import bda_pkg::*;

   cfg_type    cfg;
   result_type next_result;
   result_type rsp_data;
   logic       out_ready;
   logic       item_accept;

   assign req_ready   = out_ready;
   assign item_accept = req_valid && out_ready;

   bda_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // state update happens at acceptance; result computed in the same pass
   bda_core u_core (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .item_accept    (item_accept),
      .command        (req_command),
      .sensed_buttons (req_sensed_buttons),
      .result         (next_result)
   );

   bda_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (item_accept),
      .result    (next_result),
      .ready     (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_press_event       = rsp_data.press_event;
   assign rsp_click             = rsp_data.click;
   assign rsp_debounced_buttons = rsp_data.debounced_buttons;
   assign rsp_repeat_active     = rsp_data.repeat_active;

endmodule

`default_nettype wire

[rtl/bda_checker.sv]
// Port-level checks for the debouncer, attached to the top level by bind.
// Depends on bda_pkg and button_debounce_autorepeat.
`default_nettype none

module bda_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [bda_pkg::BTN_WIDTH-1:0]       rsp_press_event,
   input wire logic                                rsp_click,
   input wire logic [bda_pkg::BTN_WIDTH-1:0]       rsp_debounced_buttons,
   input wire logic                                rsp_repeat_active
);

   // no result pending straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // an empty result register always takes an item
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // a click returns exactly the committed set, which is nonzero
   a_click_press: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_click) |->
         (rsp_press_event == rsp_debounced_buttons) && (rsp_press_event != '0))
      else $error("click without matching press");

   // no press without a click
   a_no_press_without_click: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_click) |-> (rsp_press_event == '0))
      else $error("press event without click");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_press_event)
         && $stable(rsp_click) && $stable(rsp_debounced_buttons)
         && $stable(rsp_repeat_active))
      else $error("stalled result changed");

endmodule

bind button_debounce_autorepeat bda_checker u_bda_checker (.*);

`default_nettype wire
